>>> sv/faa_pkg.sv
// Package: types, constants and helpers shared by the extent allocator files.
`timescale 1ns / 1ps
package faa_pkg;

  localparam int START_W = 17;
  localparam int UNITS_W = 18;
  localparam int BYTES_W = 21;
  localparam int OFFS_W  = 20;
  localparam int LEN_W   = 22;
  localparam int REQU_W  = 19;

  localparam int DEF_ADDR_BITS   = 20;
  localparam int DEF_MAX_EXTENTS = 64;

  localparam logic [BYTES_W-1:0] ARENA_RESET = 21'd1048576;
  localparam logic [UNITS_W-1:0] UNITS_MAX   = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX   = '1;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [UNITS_W-1:0] units;
  } ext_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_RIGHT,
    CELL_LEFT,
    CELL_LOAD,
    CELL_CLEAR
  } cell_op_t;

  function automatic logic [UNITS_W-1:0] sat_units(input logic [REQU_W:0] v);
    logic [UNITS_W-1:0] r;
    if (v > {2'b00, UNITS_MAX}) r = UNITS_MAX;
    else r = v[UNITS_W-1:0];
    return r;
  endfunction

endpackage

>>> sv/faa_cell.sv
// One cell of the extent chain: holds one free extent.
`timescale 1ns / 1ps
module faa_cell (
  input  logic             clk,
  input  faa_pkg::cell_op_t op,
  input  faa_pkg::ext_t    from_left,
  input  faa_pkg::ext_t    from_right,
  input  faa_pkg::ext_t    load_val,
  output faa_pkg::ext_t    ext
);

  always_ff @(posedge clk) begin
    case (op)
      faa_pkg::CELL_RIGHT: ext <= from_right;
      faa_pkg::CELL_LEFT:  ext <= from_left;
      faa_pkg::CELL_LOAD:  ext <= load_val;
      faa_pkg::CELL_CLEAR: ext <= '0;
      default:             ext <= ext;
    endcase
  end

endmodule

>>> sv/first_fit_extent_allocator.sv
// Top level: first-fit free-extent allocator built on a chain of extent cells.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------
//  request  | in_valid / in_ready          | action, size_bytes, offset
//  result   | out_valid / out_ready        | status, block_offset, bytes_left
//  config   | cfg_valid / cfg_ready (=1)   | cfg_data (arena_bytes)
//
// Sequence: an allocate or free rotates the cell chain once to scan, then
//   edits and loads its result into the output register; the next request
//   is taken only after that edit, not while one is still in progress.
//   Init and unused actions skip the scan and go straight to the edit.
// Reset: rst leads into an init step with the reset arena size; in_ready is low
//   during it.
// Stalls: the edit cycle waits while a previous result sits in the output
//   register unaccepted; a new request is taken whenever the controller is idle.
`timescale 1ns / 1ps
module first_fit_extent_allocator #(
  parameter int ARENA_ADDR_BITS = faa_pkg::DEF_ADDR_BITS,
  parameter int MAX_EXTENTS     = faa_pkg::DEF_MAX_EXTENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [20:0] size_bytes,
  input  logic [19:0] offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [19:0] block_offset,
  output logic [20:0] bytes_left,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data
);

  localparam int PW = $clog2(MAX_EXTENTS + 1);

  typedef enum logic [1:0] {S_BOOT, S_IDLE, S_SCAN, S_EDIT} state_t;

  state_t state;
  logic [faa_pkg::BYTES_W-1:0] arena_bytes;
  logic [faa_pkg::BYTES_W-1:0] free_bytes;
  logic [PW-1:0]               ext_count;
  logic [PW-1:0]               k;
  logic [PW-1:0]               pos;
  logic                        found;
  faa_pkg::ext_t               cur;   // extent at pos (first fit / next neighbor)
  faa_pkg::ext_t               prev;  // extent just before pos (set by free scans only)

  // latched request
  logic [1:0]                  req_act;
  logic [faa_pkg::LEN_W-1:0]   req_len;
  logic [faa_pkg::START_W-1:0] req_p;

  faa_pkg::ext_t    cells [MAX_EXTENTS];
  faa_pkg::cell_op_t ops  [MAX_EXTENTS];
  faa_pkg::ext_t    load_val;
  faa_pkg::ext_t    head;

  assign head      = cells[0];
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // incoming size rounded up to 8-byte units
  logic [faa_pkg::LEN_W-1:0]  in_len;
  assign in_len = ({1'b0, size_bytes} + faa_pkg::LEN_W'(7)) & ~faa_pkg::LEN_W'(7);

  logic [faa_pkg::REQU_W-1:0] req_units;
  assign req_units = req_len[faa_pkg::LEN_W-1:3];

  // init values from the arena register, capped at the address space
  logic [32:0] init_len;
  logic [faa_pkg::UNITS_W-1:0] init_units;
  always_comb begin
    init_len = 33'(arena_bytes & ~faa_pkg::BYTES_W'(7));
    if (init_len > (33'(1) << ARENA_ADDR_BITS)) init_len = 33'(1) << ARENA_ADDR_BITS;
    init_units = init_len[faa_pkg::BYTES_W-1:3];
  end

  // edit-cycle decision
  logic edit_go;
  logic mprev, mnext, in_scan;
  logic [faa_pkg::UNITS_W-1:0] u1, u2;
  logic [faa_pkg::BYTES_W+1:0] free_sum;
  logic do_remove, do_insert, do_load, do_init;
  logic [PW-1:0] load_idx, count_next;
  logic [faa_pkg::BYTES_W-1:0] free_next;
  logic [1:0]  status_next;
  logic [19:0] blk_next;

  assign edit_go = (state == S_EDIT) && (!out_valid || out_ready);
  assign in_scan = (k < ext_count);

  always_comb begin
    mprev = (pos != '0) &&
            (({2'b00, prev.start} + {1'b0, prev.units}) == {2'b00, req_p});
    mnext = found &&
            (({3'b000, req_p} + {1'b0, req_units}) == {3'b000, cur.start});
    u1 = faa_pkg::sat_units({1'b0, prev.units} + {1'b0, req_units});
    u2 = faa_pkg::sat_units({2'b00, u1} + {2'b00, cur.units});
    free_sum = {2'b00, free_bytes} + {1'b0, req_len};

    do_remove   = 1'b0;
    do_insert   = 1'b0;
    do_load     = 1'b0;
    do_init     = 1'b0;
    load_idx    = pos;
    load_val    = cur;
    count_next  = ext_count;
    free_next   = free_bytes;
    status_next = faa_pkg::ST_OK;
    blk_next    = '0;

    case (req_act)
      faa_pkg::ACT_ALLOC: begin
        if (req_len >= {1'b0, free_bytes}) begin
          status_next = faa_pkg::ST_NOMEM;
        end else if (req_len == '0) begin
          status_next = faa_pkg::ST_ZERO;
        end else if (!found) begin
          status_next = faa_pkg::ST_NOMEM;
        end else begin
          blk_next  = {cur.start, 3'b000};
          free_next = free_bytes - req_len[faa_pkg::BYTES_W-1:0];
          if ({1'b0, cur.units} == req_units) begin
            do_remove  = 1'b1;
            count_next = ext_count - PW'(1);
          end else begin
            do_load        = 1'b1;
            load_val.start = cur.start + req_units[faa_pkg::START_W-1:0];
            load_val.units = cur.units - req_units[faa_pkg::UNITS_W-1:0];
          end
        end
      end
      faa_pkg::ACT_FREE: begin
        if (req_len == '0) begin
          status_next = faa_pkg::ST_ZERO;
        end else if (!mprev && !mnext && ext_count == PW'(MAX_EXTENTS)) begin
          status_next = faa_pkg::ST_FULL;
        end else begin
          free_next = (free_sum > {2'b00, faa_pkg::BYTES_MAX}) ? faa_pkg::BYTES_MAX
                                                              : free_sum[faa_pkg::BYTES_W-1:0];
          do_load = 1'b1;
          if (mprev) begin
            load_idx       = pos - PW'(1);
            load_val.start = prev.start;
            load_val.units = mnext ? u2 : u1;
            if (mnext) begin
              do_remove  = 1'b1;
              count_next = ext_count - PW'(1);
            end
          end else if (mnext) begin
            load_val.start = req_p;
            load_val.units = faa_pkg::sat_units({1'b0, cur.units} + {1'b0, req_units});
          end else begin
            load_val.start = req_p;
            load_val.units = faa_pkg::sat_units({1'b0, req_units});
            do_insert  = 1'b1;
            count_next = ext_count + PW'(1);
          end
        end
      end
      faa_pkg::ACT_INIT: begin
        do_init = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_init || state == S_BOOT) begin
      load_idx       = '0;
      load_val.start = '0;
      load_val.units = init_units;
      count_next     = (init_units == '0) ? '0 : PW'(1);
      free_next      = (init_units == '0) ? '0 : init_len[faa_pkg::BYTES_W-1:0];
    end
  end

  // per-cell control
  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_EXTENTS;
    localparam int PB = (i + MAX_EXTENTS - 1) % MAX_EXTENTS;

    always_comb begin
      ops[i] = faa_pkg::CELL_HOLD;
      if (state == S_BOOT || (edit_go && do_init)) begin
        if (i == 0 && init_units != '0) ops[i] = faa_pkg::CELL_LOAD;
        else ops[i] = faa_pkg::CELL_CLEAR;
      end else if (state == S_SCAN) begin
        ops[i] = faa_pkg::CELL_RIGHT;       // rotate toward cell 0
      end else if (edit_go) begin
        if (do_load && PW'(i) == load_idx) begin
          ops[i] = faa_pkg::CELL_LOAD;
        end else if (do_remove && PW'(i) >= pos) begin
          ops[i] = (i == MAX_EXTENTS - 1) ? faa_pkg::CELL_CLEAR : faa_pkg::CELL_RIGHT;
        end else if (do_insert && PW'(i) > pos) begin
          ops[i] = faa_pkg::CELL_LEFT;
        end
      end
    end

    faa_cell u_cell (
      .clk        (clk),
      .op         (ops[i]),
      .from_left  (cells[PB]),
      .from_right (cells[NB]),
      .load_val   (load_val),
      .ext        (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_BOOT;
      arena_bytes <= faa_pkg::ARENA_RESET;
      out_valid   <= 1'b0;
      free_bytes  <= '0;
      ext_count   <= '0;
      k           <= '0;
      found       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) arena_bytes <= cfg_data;
      if (out_valid && out_ready && !edit_go) out_valid <= 1'b0;

      case (state)
        S_BOOT: begin
          ext_count  <= count_next;
          free_bytes <= free_next;
          state      <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_act <= action;
            req_len <= in_len;
            req_p   <= offset[faa_pkg::OFFS_W-1:3];
            k       <= '0;
            pos     <= ext_count;
            found   <= 1'b0;
            prev    <= '0;
            cur     <= '0;
            state   <= (action == faa_pkg::ACT_ALLOC || action == faa_pkg::ACT_FREE)
                       ? S_SCAN : S_EDIT;
          end
        end
        S_SCAN: begin
          // head holds entry k; entries are restored after a full rotation
          if (!found && in_scan) begin
            if (req_act == faa_pkg::ACT_ALLOC) begin
              if ({1'b0, head.units} >= req_units) begin
                found <= 1'b1;
                pos   <= k;
                cur   <= head;
              end
            end else if (head.start >= req_p) begin
              found <= 1'b1;
              pos   <= k;
              cur   <= head;
            end else begin
              prev <= head;
            end
          end
          k <= k + PW'(1);
          if (k == PW'(MAX_EXTENTS - 1)) state <= S_EDIT;
        end
        S_EDIT: begin
          if (edit_go) begin
            ext_count    <= count_next;
            free_bytes   <= free_next;
            status       <= status_next;
            block_offset <= blk_next;
            bytes_left   <= free_next;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ext_count <= PW'(MAX_EXTENTS))
    else $error("extent count past table size");

  a_alloc_shrinks: assert property (@(posedge clk) disable iff (rst)
    edit_go && req_act == faa_pkg::ACT_ALLOC && status_next == faa_pkg::ST_OK
    |=> free_bytes < $past(free_bytes))
    else $error("successful allocate did not reduce free bytes");

  a_full_needs_full: assert property (@(posedge clk) disable iff (rst)
    edit_go && status_next == faa_pkg::ST_FULL |-> ext_count == PW'(MAX_EXTENTS))
    else $error("table-full status with free slots");
`endif

endmodule
